>>> design/xor_zero_run_encoder_defines.svh
// assertion macros shared by the encoder modules
// they expect clk_i and rst_ni in the enclosing module
`ifndef XOR_ZERO_RUN_ENCODER_DEFINES_SVH
`define XOR_ZERO_RUN_ENCODER_DEFINES_SVH

// property must hold at every clock edge outside reset
`define XZRE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define XZRE_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> design/xzre_pkg.sv
package xzre_pkg;

  localparam int MEM_BYTES = 8192;
  localparam int RUN_CAP   = (MEM_BYTES < 8192) ? MEM_BYTES : 8192;

  localparam int BYTE_W = 8;
  localparam int RUN_W  = 14;
  localparam int LEN_W  = 15;
  localparam int CNT_W  = 2;

  localparam logic [LEN_W-1:0]  LEN_MAX      = 15'h7fff;
  localparam logic [RUN_W-1:0]  RUN_CHUNK    = 14'h100;
  localparam logic [BYTE_W-1:0] RUN_PAIR_MAX = 8'hff;

  // valid byte counts of a result
  localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [CNT_W-1:0] CNT_LIT  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_PAIR = 2'd2;

  // queue between front and back, depth must be a power of two
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // one queued job: pending run to flush, nonzero literal (0 if none), last flag
  typedef struct packed {
    logic [RUN_W-1:0]  run;
    logic [BYTE_W-1:0] lit;
    logic              last;
  } xzre_entry_t;

  typedef struct packed {
    logic        push;
    xzre_entry_t entry;
  } xzre_push_t;

  function automatic logic [LEN_W-1:0] xzre_sat_add(logic [LEN_W-1:0] len,
                                                     logic [CNT_W-1:0] n);
    logic [LEN_W:0] sum;
    sum = {1'b0, len} + {{(LEN_W+1-CNT_W){1'b0}}, n};
    return (sum > {1'b0, LEN_MAX}) ? LEN_MAX : sum[LEN_W-1:0];
  endfunction

endpackage

>>> design/xzre_front.sv
module xzre_front import xzre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] original_byte_i,
  input  logic [BYTE_W-1:0] current_byte_i,
  input  logic              final_position_i,
  input  logic              fifo_full_i,
  output xzre_push_t        push_o
);

  logic [RUN_W-1:0]  zero_run_q, zero_run_d;
  logic [BYTE_W-1:0] diff;
  logic              accept;
  logic              is_zero;

  assign diff       = original_byte_i ^ current_byte_i;
  assign is_zero    = (diff == '0);
  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;

  // zero items only grow the run, unless they close the stream
  assign push_o.push        = accept && (!is_zero || final_position_i);
  assign push_o.entry.run   = is_zero ? '0 : zero_run_q;
  assign push_o.entry.lit   = diff;
  assign push_o.entry.last  = final_position_i;

  always_comb begin
    zero_run_d = zero_run_q;
    if (accept) begin
      if (final_position_i || !is_zero) begin
        zero_run_d = '0;
      end else if (zero_run_q < RUN_W'(RUN_CAP)) begin
        zero_run_d = zero_run_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q <= '0;
    end else begin
      zero_run_q <= zero_run_d;
    end
  end

endmodule

>>> design/xzre_fifo.sv
`include "xor_zero_run_encoder_defines.svh"

module xzre_fifo import xzre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  xzre_push_t  push_i,
  input  logic        pop_i,
  output xzre_entry_t head_o,
  output logic        empty_o,
  output logic        full_o
);

  xzre_entry_t        mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i.push && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i.push && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  `XZRE_ASSERT_NEVER(a_fifo_no_overflow, push_i.push && full_o, "queue written while full")
  `XZRE_ASSERT_NEVER(a_fifo_no_underflow, pop_i && empty_o, "queue read while empty")
  `XZRE_ASSERT(a_fifo_count_bound, count_q <= (FIFO_AW+1)'(FIFO_DEPTH), "queue count too large")

endmodule

>>> design/xzre_back.sv
`include "xor_zero_run_encoder_defines.svh"

module xzre_back import xzre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xzre_entry_t       head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] first_out_o,
  output logic [BYTE_W-1:0] second_out_o,
  output logic [CNT_W-1:0]  valid_count_o,
  output logic              end_marker_o,
  output logic [LEN_W-1:0]  chunk_length_o
);

  // job being expanded
  logic              wv_q;
  logic [RUN_W-1:0]  run_q, run_d;
  logic [BYTE_W-1:0] lit_q, lit_d;
  logic              last_q;
  logic [LEN_W-1:0]  len_q, len_d, len_lit;
  logic [RUN_W-1:0]  run_m1;

  // result register
  logic              ov_q;
  logic [BYTE_W-1:0] first_q, second_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              end_q;
  logic [LEN_W-1:0]  chunk_q;

  logic              out_free, step, done, load;
  logic [BYTE_W-1:0] g_first, g_second;
  logic [CNT_W-1:0]  g_cnt;
  logic              g_end;
  logic [LEN_W-1:0]  g_chunk;

  assign out_free = !ov_q || out_ready_i;
  assign step     = wv_q && out_free;
  assign run_m1   = run_q - 1'b1;
  assign len_lit  = xzre_sat_add(len_q, CNT_LIT);

  // one result per step: full run pairs, last run pair, literal, then pad or empty close
  always_comb begin
    g_first  = '0;
    g_second = '0;
    g_cnt    = CNT_NONE;
    g_end    = 1'b0;
    g_chunk  = '0;
    run_d    = run_q;
    lit_d    = lit_q;
    len_d    = len_q;
    done     = 1'b0;
    if (run_q > RUN_CHUNK) begin
      g_second = RUN_PAIR_MAX;
      g_cnt    = CNT_PAIR;
      len_d    = xzre_sat_add(len_q, CNT_PAIR);
      run_d    = run_q - RUN_CHUNK;
    end else if (run_q != '0) begin
      g_second = run_m1[BYTE_W-1:0];
      g_cnt    = CNT_PAIR;
      len_d    = xzre_sat_add(len_q, CNT_PAIR);
      run_d    = '0;
    end else if (lit_q != '0) begin
      g_first = lit_q;
      g_cnt   = CNT_LIT;
      lit_d   = '0;
      len_d   = len_lit;
      if (!last_q) begin
        done = 1'b1;
      end else if (!len_lit[0]) begin
        done    = 1'b1;
        g_end   = 1'b1;
        g_chunk = len_lit;
        len_d   = '0;
      end
    end else begin
      done    = 1'b1;
      g_end   = 1'b1;
      g_chunk = len_q;
      g_cnt   = len_q[0] ? CNT_LIT : CNT_NONE;
      len_d   = '0;
    end
  end

  assign load  = !empty_i && (!wv_q || (step && done));
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q  <= 1'b0;
      len_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (load) begin
        wv_q <= 1'b1;
      end else if (step && done) begin
        wv_q <= 1'b0;
      end
      if (step) begin
        len_q <= len_d;
        ov_q  <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      run_q  <= head_i.run;
      lit_q  <= head_i.lit;
      last_q <= head_i.last;
    end else if (step) begin
      run_q <= run_d;
      lit_q <= lit_d;
    end
    if (step) begin
      first_q  <= g_first;
      second_q <= g_second;
      cnt_q    <= g_cnt;
      end_q    <= g_end;
      chunk_q  <= g_chunk;
    end
  end

  assign out_valid_o    = ov_q;
  assign first_out_o    = first_q;
  assign second_out_o   = second_q;
  assign valid_count_o  = cnt_q;
  assign end_marker_o   = end_q;
  assign chunk_length_o = chunk_q;

  `XZRE_ASSERT_NEVER(a_chunk_only_at_end, ov_q && !end_q && (chunk_q != '0), "length off end")
  `XZRE_ASSERT(a_len_cleared_at_end, (step && g_end) |=> (len_q == '0), "length kept after end")
  `XZRE_ASSERT(a_pair_lead_zero, (ov_q && (cnt_q == CNT_PAIR)) |-> (first_q == '0), "bad run pair")

endmodule

>>> design/xor_zero_run_encoder.sv
// xor_zero_run_encoder: xor run-length compressor for a memory image
//
// input channel (in_valid_i / in_ready_o): one item per memory position, the
// pristine byte, the current byte and final_position_i on the last position
// output channel (out_valid_o / out_ready_i): one item per emitted result,
// a run pair (0, run-1), a literal, a pad zero, or an empty closing item;
// end_marker_o and chunk_length_o are set on the last item of a stream
//
// throughput: one input item per cycle while the queue has room; the back
// end expands one result per cycle while the receiver takes results, so an
// item whose run is flushed as n pairs gives n+1 results, one more for a pad
// (up to 34 in all); path: an accepted item passes the queue, the job
// register and then the result register on its way to the outputs, and a
// busy back end or a stalled receiver can hold it in between
//
// reset clears the pending run, the length count, the queue and all valids
// when the receiver stalls the result register holds, the back end stops,
// the 4-entry queue fills and then in_ready_o drops
module xor_zero_run_encoder import xzre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] original_byte_i,
  input  logic [BYTE_W-1:0] current_byte_i,
  input  logic              final_position_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] first_out_o,
  output logic [BYTE_W-1:0] second_out_o,
  output logic [CNT_W-1:0]  valid_count_o,
  output logic              end_marker_o,
  output logic [LEN_W-1:0]  chunk_length_o
);

  xzre_push_t  push;
  xzre_entry_t head;
  logic        fifo_empty, fifo_full, pop;

  // front: xor, count zero runs, queue a job on each nonzero or final item
  xzre_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .original_byte_i  (original_byte_i),
    .current_byte_i   (current_byte_i),
    .final_position_i (final_position_i),
    .fifo_full_i      (fifo_full),
    .push_o           (push)
  );

  // short queue decoupling the two sides
  xzre_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  // back: expand each job into result items, track length and padding
  xzre_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .empty_i        (fifo_empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .first_out_o    (first_out_o),
    .second_out_o   (second_out_o),
    .valid_count_o  (valid_count_o),
    .end_marker_o   (end_marker_o),
    .chunk_length_o (chunk_length_o)
  );

endmodule

>>> tb/xzre_result_check.sv
`timescale 1ns / 1ps
module xzre_result_check import xzre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [BYTE_W-1:0] original_byte_i,
  input  logic [BYTE_W-1:0] current_byte_i,
  input  logic              final_position_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [BYTE_W-1:0] first_out_i,
  input  logic [BYTE_W-1:0] second_out_i,
  input  logic [CNT_W-1:0]  valid_count_i,
  input  logic              end_marker_i,
  input  logic [LEN_W-1:0]  chunk_length_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [BYTE_W-1:0] first_out;
    logic [BYTE_W-1:0] second_out;
    logic [CNT_W-1:0]  valid_count;
    logic              end_marker;
    logic [LEN_W-1:0]  chunk_length;
  } enc_result_t;

  enc_result_t      expected_results[$];
  enc_result_t      oldest;
  logic [RUN_W-1:0] zero_count;
  logic [LEN_W-1:0] byte_total;

  function automatic enc_result_t make_result(logic [BYTE_W-1:0] lead,
                                              logic [BYTE_W-1:0] follow,
                                              logic [CNT_W-1:0]  n);
    enc_result_t r;
    r             = '0;
    r.first_out   = lead;
    r.second_out  = follow;
    r.valid_count = n;
    return r;
  endfunction

  // stream length saturates instead of wrapping
  function void add_bytes(int unsigned n);
    int unsigned sum;
    sum = int'(byte_total) + n;
    byte_total = (sum > int'(LEN_MAX)) ? LEN_MAX : sum[LEN_W-1:0];
  endfunction

  task automatic encode_item(logic [BYTE_W-1:0] orig, logic [BYTE_W-1:0] cur,
                             logic last);
    logic [BYTE_W-1:0] diff;
    logic [RUN_W-1:0]  run_m1;
    int                produced;
    enc_result_t       closing;
    diff     = orig ^ cur;
    produced = 0;
    if (diff == '0) begin
      if (zero_count < RUN_CAP) zero_count = zero_count + 1'b1;
    end else begin
      if (zero_count != '0) begin
        // full chunks of 256 zeros while more than one chunk is left
        while (zero_count > RUN_CHUNK) begin
          expected_results.push_back(make_result('0, RUN_PAIR_MAX, CNT_PAIR));
          add_bytes(2);
          zero_count = zero_count - RUN_CHUNK;
          produced++;
        end
        run_m1 = zero_count - 1'b1;
        expected_results.push_back(make_result('0, run_m1[BYTE_W-1:0], CNT_PAIR));
        add_bytes(2);
        zero_count = '0;
        produced++;
      end
      expected_results.push_back(make_result(diff, '0, CNT_LIT));
      add_bytes(1);
      produced++;
    end
    if (last) begin
      // pending run is dropped, odd length gets a pad byte
      if (byte_total[0]) begin
        expected_results.push_back(make_result('0, '0, CNT_LIT));
        produced++;
      end else if (produced == 0) begin
        expected_results.push_back(make_result('0, '0, CNT_NONE));
      end
      closing              = expected_results.pop_back();
      closing.end_marker   = 1'b1;
      closing.chunk_length = byte_total;
      expected_results.push_back(closing);
      zero_count = '0;
      byte_total = '0;
    end
  endtask

  function void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      zero_count   = '0;
      byte_total   = '0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i)
        encode_item(original_byte_i, current_byte_i, final_position_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: first_out %0d second_out %0d valid_count %0d",
                 first_out_i, second_out_i, valid_count_i);
          fail_count_o++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("first_out", oldest.first_out, first_out_i);
          check_field("second_out", oldest.second_out, second_out_i);
          check_field("valid_count", oldest.valid_count, valid_count_i);
          check_field("end_marker", oldest.end_marker, end_marker_i);
          check_field("chunk_length", oldest.chunk_length, chunk_length_i);
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import xzre_pkg::*;

  // generous: long gaps on both sides and zero bursts dominate
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_ITEMS = 130;

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              in_ready_o;
  logic [BYTE_W-1:0] original_byte_i  = '0;
  logic [BYTE_W-1:0] current_byte_i   = '0;
  logic              final_position_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i      = 1'b0;
  logic [BYTE_W-1:0] first_out_o;
  logic [BYTE_W-1:0] second_out_o;
  logic [CNT_W-1:0]  valid_count_o;
  logic              end_marker_o;
  logic [LEN_W-1:0]  chunk_length_o;

  int   fail_count;
  int   pending;
  int   cycles       = 0;
  int   items_sent   = 0;
  int   rx_wait      = 0;
  logic in_fire      = 1'b0;
  bit   tx_gaps      = 1'b1;
  bit   rx_stalls    = 1'b1;

  // a lone zero, and one past the 256-zero chunk so two pairs come out
  int boundary_runs[2] = '{1, 257};

  always #2 clk_i = ~clk_i;

  xor_zero_run_encoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .original_byte_i  (original_byte_i),
    .current_byte_i   (current_byte_i),
    .final_position_i (final_position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .first_out_o      (first_out_o),
    .second_out_o     (second_out_o),
    .valid_count_o    (valid_count_o),
    .end_marker_o     (end_marker_o),
    .chunk_length_o   (chunk_length_o)
  );

  xzre_result_check result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .original_byte_i  (original_byte_i),
    .current_byte_i   (current_byte_i),
    .final_position_i (final_position_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .first_out_i      (first_out_o),
    .second_out_i     (second_out_o),
    .valid_count_i    (valid_count_o),
    .end_marker_i     (end_marker_o),
    .chunk_length_i   (chunk_length_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // watchdog, a hang or a lost result ends here
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("xor_zero_run_encoder: mismatch");
      $finish;
    end
  end

  // input handshake seen at the last rising edge, read back at the falling edge
  always @(posedge clk_i) in_fire <= in_valid_i && in_ready_o;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // receiver: random stall stretches, or always ready when stalls are off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (!rx_stalls) begin
      out_ready_i <= 1'b1;
    end else if (rx_wait != 0) begin
      out_ready_i <= 1'b0;
      rx_wait     <= rx_wait - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 2) == 0) rx_wait <= gap_len();
    end
  end

  // drop valid and wait out the given pause, nothing happens for n == 0
  task automatic pause(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // present one item at a falling edge and hold it until accepted
  task automatic send_item(logic [BYTE_W-1:0] orig, logic [BYTE_W-1:0] cur,
                           logic last);
    in_valid_i       <= 1'b1;
    original_byte_i  <= orig;
    current_byte_i   <= cur;
    final_position_i <= last;
    @(negedge clk_i);
    while (!in_fire) @(negedge clk_i);
    items_sent++;
    if (tx_gaps) pause(gap_len());
  endtask

  // random image byte, current byte chosen so the xor equals diff
  task automatic send_diff(logic [BYTE_W-1:0] diff, logic last);
    logic [BYTE_W-1:0] orig;
    orig = BYTE_W'($urandom_range(0, 255));
    send_item(orig, orig ^ diff, last);
  endtask

  task automatic zero_burst(int n);
    repeat (n) send_diff('0, 1'b0);
  endtask

  // nonzero literal, extremes favored
  function automatic logic [BYTE_W-1:0] random_lit();
    case ($urandom_range(0, 9))
      0:       return 8'hff;
      1:       return 8'h01;
      2:       return 8'h80;
      default: return BYTE_W'($urandom_range(1, 255));
    endcase
  endfunction

  // sender holds off until every expected result has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // well-formed stream: literals and zero runs of mixed length, then a final item
  task automatic random_stream();
    int segs;
    int r;
    segs = $urandom_range(0, 20);
    repeat (segs) begin
      r = $urandom_range(0, 99);
      if (r < 2) zero_burst($urandom_range(250, 262));
      else if (r < 45) zero_burst($urandom_range(1, 6));
      else send_diff(random_lit(), 1'b0);
    end
    send_diff($urandom_range(0, 1) ? random_lit() : 8'h00, 1'b1);
  endtask

  initial begin
    int start;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // final item with nothing to emit: empty closing item
    send_item(8'h00, 8'h00, 1'b1);
    // lone literal, odd length so the pad carries the end marker
    send_item(8'hff, 8'h00, 1'b1);
    // single zeros flushed as (0,0) pairs, even length ends on the literal
    send_item(8'hff, 8'hff, 1'b0);
    send_item(8'h00, 8'hff, 1'b0);
    send_item(8'h5a, 8'h5a, 1'b0);
    send_item(8'h01, 8'h00, 1'b1);
    // trailing run dropped, pad after an odd length
    send_item(8'h80, 8'h00, 1'b0);
    send_item(8'h00, 8'h00, 1'b0);
    send_item(8'hff, 8'hff, 1'b0);
    send_item(8'h3c, 8'h3c, 1'b1);
    // trailing zero with even length: empty closing item after literals
    send_item(8'h7f, 8'h00, 1'b0);
    send_item(8'h00, 8'h01, 1'b0);
    send_item(8'hc3, 8'hc3, 1'b1);
    // run of two then a final literal: pair, literal, pad
    send_item(8'h00, 8'h00, 1'b0);
    send_item(8'hff, 8'hff, 1'b0);
    send_item(8'haa, 8'hba, 1'b1);
    drain();

    // short run and a run just past the chunk size
    foreach (boundary_runs[i]) begin
      zero_burst(boundary_runs[i]);
      send_diff(random_lit(), 1'b0);
    end
    send_diff(8'h00, 1'b1);
    drain();

    // random streams, idling mode changes from stream to stream
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      tx_gaps   <= ($urandom_range(0, 3) != 0);
      rx_stalls <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) drain();
      random_stream();
    end

    drain();
    // wait past the pipeline for stray results
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("xor_zero_run_encoder: match");
    end else begin
      $display("xor_zero_run_encoder: mismatch");
    end
    $finish;
  end

endmodule
